// File: design/sjeuc_pkg.sv
// ----------------------------------------------------------------------------
// Shift-JIS to EUC-JP package
// Payload types, mapping constants and the mapper's result bundle shared by
// the converter, its mapper and its checker.
// ----------------------------------------------------------------------------
package sjeuc_pkg;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t in_byte;
        logic  end_of_text;
    } sjis_item_t;

    typedef struct packed {
        byte_t out_byte;
        logic  last_of_run;
        logic  text_done;
    } euc_item_t;

    // Number of result bytes one input causes: zero, one or two.
    typedef logic [1:0] count_t;

    typedef struct packed {
        count_t    count;
        euc_item_t first;
        euc_item_t second;
        logic      lead_pending;
        byte_t     held_lead;
    } map_result_t;

    localparam byte_t ASCII_LIMIT     = 8'h80;
    localparam byte_t LEAD_LO_FIRST   = 8'h81;
    localparam byte_t LEAD_LO_LAST    = 8'h9f;
    localparam byte_t LEAD_HI_FIRST   = 8'he0;
    localparam byte_t LEAD_HI_LAST    = 8'hfc;
    localparam byte_t TRAIL_SPLIT     = 8'h9f;
    localparam byte_t TRAIL_GAP       = 8'h7f;
    localparam byte_t LEAD_OFS_HI_A   = 8'he0;
    localparam byte_t LEAD_OFS_LO_A   = 8'h60;
    localparam byte_t LEAD_OFS_HI_B   = 8'he1;
    localparam byte_t LEAD_OFS_LO_B   = 8'h61;
    localparam byte_t TRAIL_OFS_A     = 8'h02;
    localparam byte_t TRAIL_OFS_B     = 8'h60;
    localparam byte_t SS2_PREFIX      = 8'h8e;

    localparam count_t CNT_NONE = 2'd0;
    localparam count_t CNT_ONE  = 2'd1;
    localparam count_t CNT_TWO  = 2'd2;

endpackage

// File: design/sjis_to_eucjp_converter.sv
// ----------------------------------------------------------------------------
// Shift-JIS to EUC-JP converter
// Data path: an input is registered in the source stage, mapped, and loaded into
// the result buffer, which offers its first result byte. Throughput: one result
// byte per cycle while euc_ready is high; a held lead byte causes no result byte.
// The result buffer has a single output port and takes the next input as its last byte leaves.
// Reset: rst_n clears the held lead byte and empties both register stages.
// ----------------------------------------------------------------------------
module sjis_to_eucjp_converter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sjis_valid,
    output logic                   sjis_ready,
    input  sjeuc_pkg::sjis_item_t  sjis_item,
    output logic                   euc_valid,
    input  logic                   euc_ready,
    output sjeuc_pkg::euc_item_t   euc_item
);

    logic                   src_valid_reg;
    sjeuc_pkg::sjis_item_t  src_item_reg;
    logic                   lead_pending_reg;
    sjeuc_pkg::byte_t       held_lead_reg;
    sjeuc_pkg::count_t      cnt_reg;
    sjeuc_pkg::count_t      cnt_next;
    sjeuc_pkg::euc_item_t   first_reg;
    sjeuc_pkg::euc_item_t   second_reg;
    sjeuc_pkg::map_result_t map_res;
    logic                   out_fire;
    logic                   load;

    sjeuc_map u_map (
        .item         (src_item_reg),
        .lead_pending (lead_pending_reg),
        .held_lead    (held_lead_reg),
        .result       (map_res)
    );

    assign out_fire   = euc_valid && euc_ready;
    // The buffer takes a new transaction once it is empty or about to be.
    assign load       = src_valid_reg
                     && ((cnt_reg == sjeuc_pkg::CNT_NONE)
                      || ((cnt_reg == sjeuc_pkg::CNT_ONE) && out_fire));
    assign sjis_ready = !src_valid_reg || load;
    assign euc_valid  = (cnt_reg != sjeuc_pkg::CNT_NONE);
    assign euc_item   = first_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = map_res.count;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - sjeuc_pkg::CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg    <= 1'b0;
            lead_pending_reg <= 1'b0;
            held_lead_reg    <= '0;
            cnt_reg          <= sjeuc_pkg::CNT_NONE;
        end
        else
        begin
            if (sjis_ready)
            begin
                src_valid_reg <= sjis_valid;
            end
            if (load)
            begin
                lead_pending_reg <= map_res.lead_pending;
                held_lead_reg    <= map_res.held_lead;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sjis_ready && sjis_valid)
        begin
            src_item_reg <= sjis_item;
        end
        if (load)
        begin
            first_reg  <= map_res.first;
            second_reg <= map_res.second;
        end
        else if (out_fire)
        begin
            first_reg <= second_reg;
        end
    end

endmodule

// File: design/sjeuc_map.sv
// ----------------------------------------------------------------------------
// Shift-JIS to EUC-JP byte mapper
// Combinational step: given one input byte and the held lead state, gives
// the result bytes and the next held lead state.
// ----------------------------------------------------------------------------
module sjeuc_map (
    input  sjeuc_pkg::sjis_item_t  item,
    input  logic                   lead_pending,
    input  sjeuc_pkg::byte_t       held_lead,
    output sjeuc_pkg::map_result_t result
);

    sjeuc_pkg::byte_t b;
    sjeuc_pkg::byte_t lead_x2;
    sjeuc_pkg::byte_t lead_map;
    sjeuc_pkg::byte_t trail_map;
    logic             lead_hi;
    logic             is_lead;

    assign b       = item.in_byte;
    assign lead_x2 = {held_lead[6:0], 1'b0};
    assign lead_hi = (held_lead >= sjeuc_pkg::LEAD_HI_FIRST);
    assign is_lead = ((b >= sjeuc_pkg::LEAD_LO_FIRST) && (b <= sjeuc_pkg::LEAD_LO_LAST))
                  || ((b >= sjeuc_pkg::LEAD_HI_FIRST) && (b <= sjeuc_pkg::LEAD_HI_LAST));

    always_comb
    begin
        if (b >= sjeuc_pkg::TRAIL_SPLIT)
        begin
            lead_map  = lead_x2 - (lead_hi ? sjeuc_pkg::LEAD_OFS_HI_A
                                           : sjeuc_pkg::LEAD_OFS_LO_A);
            trail_map = b + sjeuc_pkg::TRAIL_OFS_A;
        end
        else if (b != 8'h00)
        begin
            lead_map  = lead_x2 - (lead_hi ? sjeuc_pkg::LEAD_OFS_HI_B
                                           : sjeuc_pkg::LEAD_OFS_LO_B);
            trail_map = b + sjeuc_pkg::TRAIL_OFS_B
                      + {7'd0, (b < sjeuc_pkg::TRAIL_GAP)};
        end
        else
        begin
            // A zero trail byte leaves the pair untouched.
            lead_map  = held_lead;
            trail_map = b;
        end
    end

    always_comb
    begin
        result              = '0;
        result.lead_pending = 1'b0;
        result.held_lead    = '0;
        if (lead_pending)
        begin
            result.count  = sjeuc_pkg::CNT_TWO;
            result.first  = '{out_byte: lead_map, last_of_run: 1'b0, text_done: 1'b0};
            result.second = '{out_byte: trail_map, last_of_run: 1'b1,
                              text_done: item.end_of_text};
        end
        else if (b < sjeuc_pkg::ASCII_LIMIT)
        begin
            result.count = sjeuc_pkg::CNT_ONE;
            result.first = '{out_byte: b, last_of_run: 1'b1, text_done: item.end_of_text};
        end
        else if (is_lead)
        begin
            if (item.end_of_text)
            begin
                // A lead byte that ends the text has no trail and goes out alone.
                result.count = sjeuc_pkg::CNT_ONE;
                result.first = '{out_byte: b, last_of_run: 1'b1, text_done: 1'b1};
            end
            else
            begin
                result.count        = sjeuc_pkg::CNT_NONE;
                result.lead_pending = 1'b1;
                result.held_lead    = b;
            end
        end
        else
        begin
            result.count  = sjeuc_pkg::CNT_TWO;
            result.first  = '{out_byte: sjeuc_pkg::SS2_PREFIX, last_of_run: 1'b0,
                              text_done: 1'b0};
            result.second = '{out_byte: b, last_of_run: 1'b1,
                              text_done: item.end_of_text};
        end
    end

endmodule

// File: design/sjeuc_checker.sv
// ----------------------------------------------------------------------------
// Shift-JIS to EUC-JP converter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sjeuc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  euc_valid,
    input logic                  euc_ready,
    input sjeuc_pkg::euc_item_t  euc_item
);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        euc_valid && !euc_ready |=> euc_valid)
        else $error("result withdrawn while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        euc_valid && !euc_ready |=> $stable(euc_item))
        else $error("result changed while stalled");

    // The end of the text always closes a run.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        euc_valid && euc_item.text_done |-> euc_item.last_of_run)
        else $error("text_done without last_of_run");

    // The second byte of a pair is already buffered behind the first.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        euc_valid && euc_ready && !euc_item.last_of_run |=> euc_valid)
        else $error("second byte of a pair missing");

endmodule

bind sjis_to_eucjp_converter sjeuc_checker u_sjeuc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .euc_valid (euc_valid),
    .euc_ready (euc_ready),
    .euc_item  (euc_item)
);
